// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// In synthesis builds (SYNTH defined) every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define VMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define VMT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define VMT_ASSERT(lbl, clk, rst_n, prop, msg)

`define VMT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== rtl/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg
// Types and constants of the virtio MMIO transport register slave.
// ----------------------------------------------------------------------------
`default_nettype none

package vmt_pkg;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} vmt_op_t;

	typedef struct packed {
		vmt_op_t     op;
		logic [11:0] offset;
		logic [31:0] write_data;
	} vmt_access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        queue_kick;
		logic        irq_pending;
		logic        device_reset;
	} vmt_result_t;

	// identification values
	localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
	localparam logic [31:0] VERSION_VAL   = 32'd2;
	localparam logic [31:0] DEVICE_ID     = 32'd16;
	localparam logic [31:0] VENDOR_VALUE  = 32'h554D_4551;
	localparam logic [31:0] QUEUE_SIZE    = 32'd256;
	localparam logic [31:0] SHM_NONE      = 32'hFFFF_FFFF;
	localparam logic [31:0] SCANOUT_COUNT = 32'd1;

	localparam logic [63:0] DEV_FEATURES_RST = 64'h0000_0001_0000_0000;

	// status bit index of the feature-accept flag
	localparam int unsigned STATUS_FEAT_OK_BIT = 3;

	// register offsets
	localparam logic [11:0] OFF_MAGIC       = 12'h000;
	localparam logic [11:0] OFF_VERSION     = 12'h004;
	localparam logic [11:0] OFF_DEVICE_ID   = 12'h008;
	localparam logic [11:0] OFF_VENDOR      = 12'h00C;
	localparam logic [11:0] OFF_DEV_FEAT    = 12'h010;
	localparam logic [11:0] OFF_DEV_FEATSEL = 12'h014;
	localparam logic [11:0] OFF_DRV_FEAT    = 12'h020;
	localparam logic [11:0] OFF_DRV_FEATSEL = 12'h024;
	localparam logic [11:0] OFF_QUEUE_SEL   = 12'h030;
	localparam logic [11:0] OFF_QUEUE_MAX   = 12'h034;
	localparam logic [11:0] OFF_QUEUE_NUM   = 12'h038;
	localparam logic [11:0] OFF_QUEUE_READY = 12'h044;
	localparam logic [11:0] OFF_NOTIFY      = 12'h050;
	localparam logic [11:0] OFF_IRQ_STATUS  = 12'h060;
	localparam logic [11:0] OFF_IRQ_ACK     = 12'h064;
	localparam logic [11:0] OFF_STATUS      = 12'h070;
	localparam logic [11:0] OFF_DESC_LO     = 12'h080;
	localparam logic [11:0] OFF_DESC_HI     = 12'h084;
	localparam logic [11:0] OFF_AVAIL_LO    = 12'h090;
	localparam logic [11:0] OFF_AVAIL_HI    = 12'h094;
	localparam logic [11:0] OFF_USED_LO     = 12'h0A0;
	localparam logic [11:0] OFF_USED_HI     = 12'h0A4;
	localparam logic [11:0] OFF_SHM_LEN_LO  = 12'h0B0;
	localparam logic [11:0] OFF_SHM_LEN_HI  = 12'h0B4;
	localparam logic [11:0] OFF_CFG_GEN     = 12'h0FC;
	localparam logic [11:0] OFF_NUM_SCANOUT = 12'h108;

endpackage

`default_nettype wire

// ===== rtl/vmt_cfg_apb.sv =====
// ----------------------------------------------------------------------------
// vmt_cfg_apb
// APB configuration slave holding the 64-bit device feature mask.
// ----------------------------------------------------------------------------
`default_nettype none

module vmt_cfg_apb (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	output logic [63:0]      device_features
);
	import vmt_pkg::*;

	logic [63:0] dev_feat_q;
	logic        reg_hit;

	// only register 0 exists (byte address 0, 8 bytes wide)
	assign reg_hit = !paddr[3];
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? dev_feat_q : 64'd0;
	assign device_features = dev_feat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_feat_q <= DEV_FEATURES_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			dev_feat_q <= pwdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vmt_regfile.sv =====
// ----------------------------------------------------------------------------
// vmt_regfile
// Transport register state, access decode and per-access result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vmt_regfile #(
	parameter int unsigned NUM_QUEUES = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 acc_valid,
	input  wire vmt_pkg::vmt_access_t acc,
	input  wire logic [63:0]          device_features,
	output logic                      res_valid,
	output vmt_pkg::vmt_result_t      res
);
	import vmt_pkg::*;

	localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [31:0] QMAX = 32'(NUM_QUEUES - 1);

	logic [31:0]   dev_sel_q;
	logic [31:0]   drv_sel_q;
	logic [63:0]   drv_feat_q;
	logic [31:0]   status_q;
	logic [31:0]   irq_q;
	logic [QW-1:0] qsel_q;
	logic          ready_q [NUM_QUEUES];
	logic [63:0]   desc_q  [NUM_QUEUES];
	logic [63:0]   avail_q [NUM_QUEUES];
	logic [63:0]   used_q  [NUM_QUEUES];

	logic          is_wr;
	logic [31:0]   wdata;
	logic          q0_live;
	logic          kick;
	logic          dev_rst;
	logic          feat_bad;
	logic [31:0]   status_nxt;
	logic [31:0]   irq_nxt;
	logic [31:0]   rd;

	assign is_wr   = acc_valid && (acc.op == OP_WRITE);
	assign wdata   = acc.write_data;
	assign q0_live = ready_q[0] && (|desc_q[0]) && (|avail_q[0]) && (|used_q[0]);
	assign kick    = is_wr && (acc.offset == OFF_NOTIFY) && (wdata == 32'd0) && q0_live;
	assign dev_rst = is_wr && (acc.offset == OFF_STATUS) && (wdata == 32'd0);
	assign feat_bad = |(drv_feat_q & ~device_features);

	// feature-accept bit is refused when newly set with unsupported driver features
	always_comb begin
		status_nxt = wdata;
		if (wdata[STATUS_FEAT_OK_BIT] && !status_q[STATUS_FEAT_OK_BIT] && feat_bad) begin
			status_nxt[STATUS_FEAT_OK_BIT] = 1'b0;
		end
	end

	always_comb begin
		irq_nxt = irq_q;
		if (kick) begin
			irq_nxt = irq_q | 32'd1;
		end else if (is_wr && (acc.offset == OFF_IRQ_ACK)) begin
			irq_nxt = irq_q & ~wdata;
		end else if (dev_rst) begin
			irq_nxt = 32'd0;
		end
	end

	always_comb begin
		rd = 32'd0;
		if (acc.op == OP_READ) begin
			unique case (acc.offset)
				OFF_MAGIC:       rd = MAGIC_VALUE;
				OFF_VERSION:     rd = VERSION_VAL;
				OFF_DEVICE_ID:   rd = DEVICE_ID;
				OFF_VENDOR:      rd = VENDOR_VALUE;
				OFF_DEV_FEAT: begin
					if (dev_sel_q == 32'd0) begin
						rd = device_features[31:0];
					end else if (dev_sel_q == 32'd1) begin
						rd = device_features[63:32];
					end
				end
				OFF_QUEUE_MAX:   rd = QUEUE_SIZE;
				OFF_QUEUE_READY: rd = {31'd0, ready_q[qsel_q]};
				OFF_IRQ_STATUS:  rd = irq_q;
				OFF_STATUS:      rd = status_q;
				OFF_SHM_LEN_LO:  rd = SHM_NONE;
				OFF_SHM_LEN_HI:  rd = SHM_NONE;
				OFF_CFG_GEN:     rd = 32'd0;
				OFF_NUM_SCANOUT: rd = SCANOUT_COUNT;
				default:         rd = 32'd0;
			endcase
		end
	end

	assign res_valid        = acc_valid;
	assign res.read_data    = rd;
	assign res.queue_kick   = kick;
	assign res.irq_pending  = |irq_nxt;
	assign res.device_reset = dev_rst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_sel_q  <= '0;
			drv_sel_q  <= '0;
			drv_feat_q <= '0;
			status_q   <= '0;
			irq_q      <= '0;
			qsel_q     <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				ready_q[i] <= 1'b0;
				desc_q[i]  <= '0;
				avail_q[i] <= '0;
				used_q[i]  <= '0;
			end
		end else if (is_wr) begin
			irq_q <= irq_nxt;
			unique case (acc.offset)
				OFF_DEV_FEATSEL: dev_sel_q <= wdata;
				OFF_DRV_FEATSEL: drv_sel_q <= wdata;
				OFF_DRV_FEAT: begin
					if (drv_sel_q == 32'd0) begin
						drv_feat_q[31:0] <= wdata;
					end else if (drv_sel_q == 32'd1) begin
						drv_feat_q[63:32] <= wdata;
					end
				end
				OFF_QUEUE_SEL: begin
					qsel_q <= (wdata > QMAX) ? QMAX[QW-1:0] : wdata[QW-1:0];
				end
				OFF_QUEUE_READY: ready_q[qsel_q] <= (wdata != 32'd0);
				OFF_STATUS: begin
					status_q <= status_nxt;
					if (dev_rst) begin
						drv_feat_q <= '0;
						for (int i = 0; i < NUM_QUEUES; i++) begin
							ready_q[i] <= 1'b0;
							desc_q[i]  <= '0;
							avail_q[i] <= '0;
							used_q[i]  <= '0;
						end
					end
				end
				OFF_DESC_LO:  desc_q[qsel_q][31:0]   <= wdata;
				OFF_DESC_HI:  desc_q[qsel_q][63:32]  <= wdata;
				OFF_AVAIL_LO: avail_q[qsel_q][31:0]  <= wdata;
				OFF_AVAIL_HI: avail_q[qsel_q][63:32] <= wdata;
				OFF_USED_LO:  used_q[qsel_q][31:0]   <= wdata;
				OFF_USED_HI:  used_q[qsel_q][63:32]  <= wdata;
				default: ;
			endcase
		end
	end

	// a kick always leaves an interrupt pending
	`VMT_ASSERT(a_kick_irq, clk, arst_n, res_valid && res.queue_kick |-> res.irq_pending, "kick without pending interrupt")
	// a device reset clears all interrupt status
	`VMT_ASSERT(a_rst_irq, clk, arst_n, res_valid && res.device_reset |=> irq_q == 32'd0, "interrupt status survived device reset")
	// after a device reset queue 0 can never be kicked on the next access
	`VMT_ASSERT(a_rst_q0, clk, arst_n, res_valid && res.device_reset |=> !q0_live, "queue 0 live after device reset")
	// reads never change the interrupt status
	`VMT_ASSERT(a_rd_irq, clk, arst_n, acc_valid && acc.op == OP_READ |=> $stable(irq_q), "read changed interrupt status")

endmodule

`default_nettype wire

// ===== rtl/vmt_out_skid.sv =====
// ----------------------------------------------------------------------------
// vmt_out_skid
// Result register with one skid entry toward the downstream channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vmt_out_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 res_valid,
	input  wire vmt_pkg::vmt_result_t res,
	output logic                      full,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output vmt_pkg::vmt_result_t      out_data
);
	import vmt_pkg::*;

	logic        out_valid_q;
	vmt_result_t out_q;
	logic        skid_valid_q;
	vmt_result_t skid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	`VMT_NEVER(a_no_overrun, clk, arst_n, res_valid && skid_valid_q, "beat arrived with skid full")
	`VMT_ASSERT(a_skid_behind, clk, arst_n, skid_valid_q |-> out_valid_q, "skid holds beat while output empty")
	`VMT_ASSERT(a_skid_cause, clk, arst_n, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall), "skid filled without a stall")

endmodule

`default_nettype wire

// ===== rtl/virtio_mmio_transport_registers_core.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_transport_registers_core
// Register slave of a virtio MMIO (v2) transport for a two-queue GPU device.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one register access per beat (op, offset, write_data). A beat is
//    taken on a clock edge with in_valid high and in_stall low.
//  - out_*: one result beat per access (read_data, queue_kick, irq_pending,
//    device_reset), in access order.
//  - APB port: register 0 (byte address 0, 64 bits) is the device feature
//    mask; reset value has bit 32 (version 1) set. Write it only while idle.
//  - Output: the result of each access is registered before it shows on out_*.
//  - Throughput: one access per cycle while in_stall is low. Decode, state
//    update and the result are one pass of logic ending in the result register.
//  - Stall: when out_stall holds the result register, one more result goes
//    into a skid entry; in_stall rises only while that entry is full, so a
//    downstream stall blocks the input at most for as long as it lasts.
//  - Reset: all transport state clears, no result is pending, in_stall low.
// ----------------------------------------------------------------------------
`default_nettype none

module virtio_mmio_transport_registers_core #(
	parameter int unsigned NUM_QUEUES = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// access channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire vmt_pkg::vmt_access_t in_data,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output vmt_pkg::vmt_result_t      out_data,
	// configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [63:0]          pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);
	import vmt_pkg::*;

	logic        skid_full;
	logic        acc_valid;
	logic        res_valid;
	vmt_result_t res;
	logic [63:0] device_features;

	// input blocks only while the skid entry is occupied
	assign in_stall  = skid_full;
	assign acc_valid = in_valid && !skid_full;

	vmt_cfg_apb u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.device_features (device_features)
	);

	// decode and state update; result is combinational off the accepted beat
	vmt_regfile #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc_valid       (acc_valid),
		.acc             (in_data),
		.device_features (device_features),
		.res_valid       (res_valid),
		.res             (res)
	);

	// result register plus skid entry
	vmt_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/vmt_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_tb_pkg
// Shadow copy of the transport registers and the queue of expected result beats.
// ----------------------------------------------------------------------------

package vmt_tb_pkg;

	import vmt_pkg::*;

	class transport_shadow;

		logic [63:0] dev_feat;
		logic [31:0] dev_sel;
		logic [31:0] drv_sel;
		logic [63:0] drv_feat;
		logic [31:0] status;
		logic [31:0] isr;
		logic        qsel;
		logic        ready [2];
		logic [63:0] desc [2];
		logic [63:0] avail [2];
		logic [63:0] used [2];

		vmt_result_t expected_results[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned kicks;
		int unsigned resets;

		function new();
			dev_feat = DEV_FEATURES_RST;
			dev_sel  = '0;
			drv_sel  = '0;
			drv_feat = '0;
			status   = '0;
			isr      = '0;
			qsel     = 1'b0;
			for (int i = 0; i < 2; i++) begin
				ready[i] = 1'b0;
				desc[i]  = '0;
				avail[i] = '0;
				used[i]  = '0;
			end
			errors  = 0;
			checked = 0;
			kicks   = 0;
			resets  = 0;
		endfunction

		// apply one accepted access to the shadow state, queue its result
		function void note_access(vmt_access_t a);
			vmt_result_t res;
			logic [31:0] v;
			logic [31:0] prev;
			res = '0;
			v   = a.write_data;
			if (a.op == OP_READ) begin
				case (a.offset)
					OFF_MAGIC:       res.read_data = MAGIC_VALUE;
					OFF_VERSION:     res.read_data = VERSION_VAL;
					OFF_DEVICE_ID:   res.read_data = DEVICE_ID;
					OFF_VENDOR:      res.read_data = VENDOR_VALUE;
					OFF_DEV_FEAT: begin
						if (dev_sel == 0)
							res.read_data = dev_feat[31:0];
						else if (dev_sel == 1)
							res.read_data = dev_feat[63:32];
					end
					OFF_QUEUE_MAX:   res.read_data = QUEUE_SIZE;
					OFF_QUEUE_READY: res.read_data = {31'd0, ready[qsel]};
					OFF_IRQ_STATUS:  res.read_data = isr;
					OFF_STATUS:      res.read_data = status;
					OFF_SHM_LEN_LO:  res.read_data = SHM_NONE;
					OFF_SHM_LEN_HI:  res.read_data = SHM_NONE;
					OFF_NUM_SCANOUT: res.read_data = SCANOUT_COUNT;
					default: ;
				endcase
			end else begin
				case (a.offset)
					OFF_DEV_FEATSEL: dev_sel = v;
					OFF_DRV_FEATSEL: drv_sel = v;
					OFF_DRV_FEAT: begin
						if (drv_sel == 0)
							drv_feat[31:0] = v;
						else if (drv_sel == 1)
							drv_feat[63:32] = v;
					end
					// two queues: any nonzero select lands on the last one
					OFF_QUEUE_SEL:   qsel = (v != 0);
					OFF_QUEUE_READY: ready[qsel] = (v != 0);
					OFF_NOTIFY: begin
						if (v == 0 && ready[0] && desc[0] != 0 && avail[0] != 0 &&
								used[0] != 0) begin
							isr[0] = 1'b1;
							res.queue_kick = 1'b1;
						end
					end
					OFF_IRQ_ACK: isr &= ~v;
					OFF_STATUS: begin
						prev   = status;
						status = v;
						if (v[STATUS_FEAT_OK_BIT] && !prev[STATUS_FEAT_OK_BIT] &&
								(drv_feat & ~dev_feat) != 0)
							status[STATUS_FEAT_OK_BIT] = 1'b0;
						if (v == 0) begin
							for (int i = 0; i < 2; i++) begin
								ready[i] = 1'b0;
								desc[i]  = '0;
								avail[i] = '0;
								used[i]  = '0;
							end
							isr      = '0;
							drv_feat = '0;
							res.device_reset = 1'b1;
						end
					end
					OFF_DESC_LO:  desc[qsel][31:0]   = v;
					OFF_DESC_HI:  desc[qsel][63:32]  = v;
					OFF_AVAIL_LO: avail[qsel][31:0]  = v;
					OFF_AVAIL_HI: avail[qsel][63:32] = v;
					OFF_USED_LO:  used[qsel][31:0]   = v;
					OFF_USED_HI:  used[qsel][63:32]  = v;
					default: ;
				endcase
			end
			res.irq_pending = (isr != 0);
			expected_results.insert(expected_results.size(), res);
		endfunction

		function void check_result(vmt_result_t r);
			vmt_result_t e;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", r);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			checked++;
			if (r.queue_kick === 1'b1) kicks++;
			if (r.device_reset === 1'b1) resets++;
			if (r.read_data !== e.read_data) begin
				$error("read_data: expected %h, got %h", e.read_data, r.read_data);
				errors++;
			end
			if (r.queue_kick !== e.queue_kick) begin
				$error("queue_kick: expected %b, got %b", e.queue_kick, r.queue_kick);
				errors++;
			end
			if (r.irq_pending !== e.irq_pending) begin
				$error("irq_pending: expected %b, got %b", e.irq_pending, r.irq_pending);
				errors++;
			end
			if (r.device_reset !== e.device_reset) begin
				$error("device_reset: expected %b, got %b", e.device_reset, r.device_reset);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

	endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the virtio MMIO transport register slave. Directed accesses hit
// the read map and the corner cases; random driver bring-up sequences, register
// pokes and noise follow under three idle mixes and several feature masks.
// Each result beat is checked against a shadow copy of the registers.
// ----------------------------------------------------------------------------

module tb;

	import vmt_pkg::*;
	import vmt_tb_pkg::*;

	// APB address of the device feature mask (register 0, 64-bit layout)
	localparam logic [3:0] ADDR_DEV_FEATURES = 4'h0;
	// cycles with no beat on either side before the run is declared hung
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 530;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	vmt_access_t in_data;
	logic        out_valid;
	logic        out_stall;
	vmt_result_t out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	transport_shadow shadow;
	int unsigned     send_idle;
	int unsigned     recv_idle;
	int unsigned     sent;
	int unsigned     quiet;
	bit              counting;
	logic [63:0]     cur_features;

	virtio_mmio_transport_registers_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: take beats, check them, stall at the current rate.
	// Values read here right after the edge are the pre-edge ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				shadow.check_result(out_data);
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Hang detector: counts cycles in which no beat moves on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic vmt_access_t acc(vmt_op_t op, logic [11:0] off, logic [31:0] d);
		vmt_access_t a;
		a.op         = op;
		a.offset     = off;
		a.write_data = d;
		return a;
	endfunction

	// Present one access, hold it until taken, then update the shadow.
	// in_valid stays high across back-to-back beats.
	task automatic send(input vmt_access_t a);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= a;
		do @(posedge clk); while (in_stall);
		shadow.note_access(a);
		if (counting) sent++;
	endtask

	task automatic rd(input logic [11:0] off);
		send(acc(OP_READ, off, $urandom));
	endtask

	task automatic wr(input logic [11:0] off, input logic [31:0] d);
		send(acc(OP_WRITE, off, d));
	endtask

	// Hold the input off until every result beat is back, then let the block idle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_features(input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DEV_FEATURES;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.dev_feat = value;
		cur_features    = value;
	endtask

	function automatic logic [11:0] reg_offset();
		case ($urandom_range(25))
			0:  return OFF_MAGIC;
			1:  return OFF_VERSION;
			2:  return OFF_DEVICE_ID;
			3:  return OFF_VENDOR;
			4:  return OFF_DEV_FEAT;
			5:  return OFF_DEV_FEATSEL;
			6:  return OFF_DRV_FEAT;
			7:  return OFF_DRV_FEATSEL;
			8:  return OFF_QUEUE_SEL;
			9:  return OFF_QUEUE_MAX;
			10: return OFF_QUEUE_NUM;
			11: return OFF_QUEUE_READY;
			12: return OFF_NOTIFY;
			13: return OFF_IRQ_STATUS;
			14: return OFF_IRQ_ACK;
			15: return OFF_STATUS;
			16: return OFF_DESC_LO;
			17: return OFF_DESC_HI;
			18: return OFF_AVAIL_LO;
			19: return OFF_AVAIL_HI;
			20: return OFF_USED_LO;
			21: return OFF_USED_HI;
			22: return OFF_SHM_LEN_LO;
			23: return OFF_SHM_LEN_HI;
			24: return OFF_CFG_GEN;
			default: return OFF_NUM_SCANOUT;
		endcase
	endfunction

	// Driver bring-up of one queue with random content: reset, ack, driver,
	// feature negotiation, queue setup, notify and interrupt handling.
	task automatic bringup();
		logic        q;
		int unsigned zero_addr;
		logic [31:0] feat_word;
		q         = ($urandom_range(3) == 0);
		zero_addr = $urandom_range(7);
		if ($urandom_range(3) != 0) wr(OFF_STATUS, 32'd0);
		wr(OFF_STATUS, 32'd1);
		wr(OFF_STATUS, 32'd3);
		for (int h = 0; h < 2; h++) begin
			wr(OFF_DRV_FEATSEL, ($urandom_range(9) == 0) ? $urandom : h);
			// mostly a subset of what the device offers, so the accept bit sticks
			feat_word = $urandom;
			if ($urandom_range(3) != 0)
				feat_word &= (h == 0) ? cur_features[31:0] : cur_features[63:32];
			wr(OFF_DRV_FEAT, feat_word);
		end
		wr(OFF_STATUS, 32'h0000_000B);
		rd(OFF_STATUS);
		wr(OFF_QUEUE_SEL, ($urandom_range(7) == 0) ? $urandom : {31'd0, q});
		wr(OFF_DESC_LO,  (zero_addr == 0) ? 32'd0 : $urandom);
		wr(OFF_DESC_HI,  (zero_addr == 0) ? 32'd0 : $urandom);
		wr(OFF_AVAIL_LO, (zero_addr == 1) ? 32'd0 : $urandom);
		wr(OFF_AVAIL_HI, (zero_addr == 1) ? 32'd0 : $urandom);
		wr(OFF_USED_LO,  (zero_addr == 2) ? 32'd0 : $urandom);
		wr(OFF_USED_HI,  (zero_addr == 2) ? 32'd0 : $urandom);
		wr(OFF_QUEUE_READY, ($urandom_range(5) == 0) ? 32'd0 : ($urandom | 32'd1));
		rd(OFF_QUEUE_READY);
		repeat ($urandom_range(1, 3))
			wr(OFF_NOTIFY, ($urandom_range(7) == 0) ? $urandom : 32'd0);
		rd(OFF_IRQ_STATUS);
		wr(OFF_IRQ_ACK, $urandom_range(1) ? 32'd1 : $urandom);
		rd(OFF_IRQ_STATUS);
		wr(OFF_DEV_FEATSEL, $urandom_range(2));
		rd(OFF_DEV_FEAT);
	endtask

	task automatic random_traffic(input int unsigned target);
		int unsigned goal;
		bit          paused;
		goal   = sent + target;
		paused = 0;
		while (sent < goal) begin
			// once per phase the sender waits out every outstanding result
			if (!paused && sent + target / 2 >= goal) begin
				wait_drained();
				paused = 1;
			end
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: bringup();
				11, 12, 13, 14, 15, 16:
					repeat ($urandom_range(1, 4))
						send(acc(vmt_op_t'($urandom_range(1)), reg_offset(),
							$urandom_range(1) ? $urandom : $urandom_range(3)));
				default: begin
					// noise: any offset, aligned or not; not counted
					counting = 0;
					repeat ($urandom_range(1, 3))
						send(acc(vmt_op_t'($urandom_range(1)), 12'($urandom), $urandom));
					counting = 1;
				end
			endcase
		end
	endtask

	task automatic directed();
		rd(OFF_MAGIC);
		rd(OFF_VERSION);
		rd(OFF_DEVICE_ID);
		rd(OFF_VENDOR);
		rd(OFF_DEV_FEAT);
		wr(OFF_DEV_FEATSEL, 32'd1);
		rd(OFF_DEV_FEAT);
		// device feature select past the high half reads zero
		wr(OFF_DEV_FEATSEL, 32'hFFFF_FFFF);
		rd(OFF_DEV_FEAT);
		rd(OFF_QUEUE_MAX);
		rd(12'h002);
		rd(12'hFFF);
		rd(OFF_SHM_LEN_LO);
		rd(OFF_SHM_LEN_HI);
		rd(OFF_CFG_GEN);
		rd(OFF_NUM_SCANOUT);
		// driver feature select past the high half drops the write
		wr(OFF_DRV_FEATSEL, 32'd2);
		wr(OFF_DRV_FEAT, 32'hFFFF_FFFF);
		// queue select saturates to the last queue
		wr(OFF_QUEUE_SEL, 32'hFFFF_FFFF);
		rd(OFF_QUEUE_READY);
		wr(OFF_QUEUE_NUM, 32'd256);
		wr(OFF_NOTIFY, 32'd1);
		wr(OFF_NOTIFY, 32'd0);
		// features the device lacks: the feature-accept status bit is refused
		wr(OFF_DRV_FEATSEL, 32'd0);
		wr(OFF_DRV_FEAT, 32'hFFFF_FFFF);
		wr(OFF_STATUS, 32'h0000_000B);
		rd(OFF_STATUS);
		wr(12'hFFC, 32'hFFFF_FFFF);
		wr(OFF_IRQ_ACK, 32'hFFFF_FFFF);
		wr(OFF_STATUS, 32'd0);
	endtask

	initial begin
		logic [63:0] settings [3];
		shadow       = new();
		cur_features = DEV_FEATURES_RST;
		send_idle    = 18;
		recv_idle    = 46;
		sent         = 0;
		counting     = 1;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		settings[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		settings[1] = 64'h0;
		settings[2] = {$urandom, $urandom} | DEV_FEATURES_RST;
		for (int p = 0; p < 3; p++) begin
			wait_drained();
			case (p)
				0: begin send_idle = 18; recv_idle = 46; end
				1: begin send_idle = 46; recv_idle = 18; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_features(settings[p]);
			random_traffic(PHASE_ITEMS);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("tb: %0d result beats checked, %0d queue kicks, %0d device resets",
			shadow.checked, shadow.checked == 0 ? 0 : shadow.kicks, shadow.resets);
		$display("tb: feature masks reset, all ones, zero and random; three idle mixes");
		if (shadow.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vmt_pkg.sv
rtl/vmt_cfg_apb.sv
rtl/vmt_regfile.sv
rtl/vmt_out_skid.sv
rtl/virtio_mmio_transport_registers_core.sv
tb/vmt_tb_pkg.sv
tb/tb.sv
